[rtl/owhs_pkg.sv]
// Shared types, constants and wave tables of the ocean wave height synthesiser.
package owhs_pkg;

	localparam int NUM_WAVES_DEF       = 6;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int MAX_WAVES           = 16;

	// pipeline layout: lane stages, then group sum, total and saturation
	localparam int LANE_ST      = 17;
	localparam int PIPE_ST      = 20;
	localparam int ST_COR0      = 7;
	localparam int CORDIC_ST    = 8;
	localparam int CORDIC_PER_ST = 2;

	localparam logic [23:0] AMP_FLOOR   = 24'd66;
	localparam logic [23:0] FREQ_FLOOR  = 24'd655;
	localparam logic [31:0] WL_FLOOR    = 32'd7;
	localparam logic [16:0] G_OVER_2PI  = 17'd102322;
	localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [40:0] BASE_NUM    = 41'd128849018880;
	localparam logic [40:0] FS_NUM      = 41'd1099511627776;

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] DIV_LAST = 6'd40;
	localparam logic [CNT_W-1:0] SQ_LAST  = 6'd31;

	typedef logic signed [17:0] dir_t;
	typedef logic [16:0] scale_t;

	localparam dir_t DIR_X [MAX_WAVES] = '{
		18'sd60423, -18'sd31583, 18'sd51801, -18'sd58618, 18'sd24340, 18'sd64005,
		18'sd60423, -18'sd31583, 18'sd51801, -18'sd58618, 18'sd24340, 18'sd64005,
		18'sd60423, -18'sd31583, 18'sd51801, -18'sd58618};
	localparam dir_t DIR_Z [MAX_WAVES] = '{
		18'sd25378, 18'sd57424, -18'sd40145, 18'sd29309, 18'sd60849, -18'sd14081,
		18'sd25378, 18'sd57424, -18'sd40145, 18'sd29309, 18'sd60849, -18'sd14081,
		18'sd25378, 18'sd57424, -18'sd40145, 18'sd29309};
	localparam scale_t AMP_SCALE [MAX_WAVES] = '{
		17'd65536, 17'd44564, 17'd24904, 17'd18350, 17'd9175, 17'd6554,
		17'd65536, 17'd44564, 17'd24904, 17'd18350, 17'd9175, 17'd6554,
		17'd65536, 17'd44564, 17'd24904, 17'd18350};
	localparam scale_t LEN_SCALE [MAX_WAVES] = '{
		17'd65536, 17'd42598, 17'd26214, 17'd19661, 17'd10486, 17'd7864,
		17'd65536, 17'd42598, 17'd26214, 17'd19661, 17'd10486, 17'd7864,
		17'd65536, 17'd42598, 17'd26214, 17'd19661};
	localparam scale_t SPD_SCALE [MAX_WAVES] = '{
		17'd57672, 17'd62259, 17'd72090, 17'd79954, 17'd85197, 17'd95027,
		17'd57672, 17'd62259, 17'd72090, 17'd79954, 17'd85197, 17'd95027,
		17'd57672, 17'd62259, 17'd72090, 17'd79954};

	localparam logic signed [17:0] ATAN_Q16 [16] = '{
		18'sd51472, 18'sd30386, 18'sd16055, 18'sd8150, 18'sd4091, 18'sd2047,
		18'sd1024, 18'sd512, 18'sd256, 18'sd128, 18'sd64, 18'sd32,
		18'sd16, 18'sd8, 18'sd4, 18'sd2};

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_LEVEL  = 2'd1,
		REG_AMP    = 2'd2,
		REG_FREQ   = 2'd3
	} reg_idx_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LDB  = 9'b000000010,
		ST_DIVB = 9'b000000100,
		ST_MULA = 9'b000001000,
		ST_LDF  = 9'b000010000,
		ST_DIVF = 9'b000100000,
		ST_MULB = 9'b001000000,
		ST_SQRT = 9'b010000000,
		ST_MULC = 9'b100000000
	} seq_st_t;

	// per-wave coefficients handed to a lane
	typedef struct packed {
		logic [31:0] wn;
		logic [31:0] ar;
		logic [24:0] ai;
	} wave_coef_t;

endpackage

[rtl/owhs_lane.sv]
// One wave lane: phase, CORDIC sine and amplitude scaling over seventeen stages.
module owhs_lane import owhs_pkg::*; #(
	parameter int WAVE_IDX        = 0,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                clk,
	input  logic [LANE_ST:1]    adv,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_z,
	input  logic [31:0]         time_s,
	input  wave_coef_t          coef,
	output logic signed [27:0]  term
);

	localparam int SH = 32 - SINE_TABLE_BITS;
	localparam logic [31:0] RND  = 32'(1) << (SH - 1);
	localparam logic [31:0] MASK = ~((32'(1) << SH) - 32'd1);
	localparam dir_t DX = DIR_X[WAVE_IDX];
	localparam dir_t DZ = DIR_Z[WAVE_IDX];

	logic signed [49:0] mx_s1, mz_s1;
	logic [31:0]        pt_s1, pt_s2, pt_s3;
	logic [63:0]        pt_full;
	logic signed [55:0] d_s2;
	logic [55:0]        plo_full;
	logic [31:0]        phi_c;
	logic [31:0]        plo_s3, phi_s3;
	logic [31:0]        a_s4, a_fold;
	logic [31:0]        mag_s5;
	logic               neg_s5;
	logic [50:0]        zp;
	logic signed [20:0] z_s6;
	logic signed [33:0] x_sc [CORDIC_ST];
	logic signed [33:0] y_sc [CORDIC_ST];
	logic signed [20:0] z_sc [CORDIC_ST];
	logic signed [33:0] xi_w [CORDIC_ST];
	logic signed [33:0] yi_w [CORDIC_ST];
	logic signed [20:0] zi_w [CORDIC_ST];
	logic signed [19:0] sr;
	logic signed [17:0] s_s15;
	logic signed [43:0] prod_s16;
	logic signed [27:0] term_s17;

	assign pt_full  = 64'(coef.ar) * 64'(time_s);
	assign plo_full = 56'(coef.wn) * 56'(d_s2[23:0]);
	assign phi_c    = coef.wn * d_s2[55:24];

	always_comb begin
		if (a_s4[31:30] == 2'b01 || a_s4[31:30] == 2'b10) begin
			a_fold = 32'h8000_0000 - a_s4;
		end else begin
			a_fold = a_s4;
		end
	end

	assign zp = 51'(mag_s5) * 51'(TWO_PI_Q16) + 51'h0_8000_0000;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mx_s1 <= 50'(DX) * 50'(pos_x);
			mz_s1 <= 50'(DZ) * 50'(pos_z);
			pt_s1 <= pt_full[39:8];
		end
		if (adv[2]) begin
			d_s2  <= 56'(mx_s1) + 56'(mz_s1);
			pt_s2 <= pt_s1;
		end
		if (adv[3]) begin
			plo_s3 <= plo_full[55:24];
			phi_s3 <= phi_c;
			pt_s3  <= pt_s2;
		end
		if (adv[4]) begin
			a_s4 <= (phi_s3 + plo_s3 + pt_s3 + RND) & MASK;
		end
		if (adv[5]) begin
			neg_s5 <= a_fold[31];
			mag_s5 <= a_fold[31] ? (32'd0 - a_fold) : a_fold;
		end
		if (adv[6]) begin
			z_s6 <= neg_s5 ? -$signed(21'(zp[50:32])) : $signed(21'(zp[50:32]));
		end
	end

	// two rotation steps per stage
	for (genvar j = 0; j < CORDIC_ST; j++) begin : g_cor
		logic signed [33:0] xv, yv, xs, ys;
		logic signed [20:0] zv;

		if (j == 0) begin : g_first
			assign xi_w[j] = CORDIC_GAIN;
			assign yi_w[j] = 34'sd0;
			assign zi_w[j] = z_s6;
		end else begin : g_next
			assign xi_w[j] = x_sc[j-1];
			assign yi_w[j] = y_sc[j-1];
			assign zi_w[j] = z_sc[j-1];
		end

		always_comb begin
			xv = xi_w[j];
			yv = yi_w[j];
			zv = zi_w[j];
			xs = '0;
			ys = '0;
			for (int m = 0; m < CORDIC_PER_ST; m++) begin
				xs = xv >>> (j * CORDIC_PER_ST + m);
				ys = yv >>> (j * CORDIC_PER_ST + m);
				if (!zv[20]) begin
					xv = xv - ys;
					yv = yv + xs;
					zv = zv - 21'(ATAN_Q16[j * CORDIC_PER_ST + m]);
				end else begin
					xv = xv + ys;
					yv = yv - xs;
					zv = zv + 21'(ATAN_Q16[j * CORDIC_PER_ST + m]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_COR0 + j]) begin
				x_sc[j] <= xv;
				y_sc[j] <= yv;
				z_sc[j] <= zv;
			end
		end
	end

	assign sr = 20'((y_sc[CORDIC_ST-1] + 34'sd8192) >>> 14);

	always_ff @(posedge clk) begin
		if (adv[15]) begin
			if (sr > 20'sd65536) begin
				s_s15 <= 18'sd65536;
			end else if (sr < -20'sd65536) begin
				s_s15 <= -18'sd65536;
			end else begin
				s_s15 <= 18'(sr);
			end
		end
		if (adv[16]) begin
			prod_s16 <= 44'($signed({1'b0, coef.ai})) * 44'(s_s15);
		end
		if (adv[17]) begin
			term_s17 <= 28'((prod_s16 + 44'sd32768) >>> 16);
		end
	end

	assign term = term_s17;

endmodule

[rtl/ocean_wave_height_synth_top.sv]
// An accepted request passes the 17 lane stages, then the group sum, total and saturation registers.
// One request per cycle while the coefficient sequencer is idle; the 20 stage registers close up bubbles on a stall.
// Reset (arst_n low) and every register write start a coefficient recompute with a
// shared divider and square root;
// s_tready stays low until it ends. Register writes are taken at any time.
// Top level of the ocean wave height synthesiser: registers, coefficient sequencer, lanes, sum.
module ocean_wave_height_synth_top import owhs_pkg::*; #(
	parameter int NUM_WAVES       = NUM_WAVES_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pos_x[31:0], pos_z[63:32], time_s[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // height[31:0]
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int WI_W = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
	localparam int NGRP = (NUM_WAVES + 3) / 4;

	logic               en_water_q;
	logic signed [31:0] level_q;
	logic [23:0]        amp_q, freq_q;

	seq_st_t            st_q;
	logic [WI_W-1:0]    wi_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [3:0]         widx;

	logic [40:0]        div_n_q, div_n_nx;
	logic [31:0]        div_r_q, div_r_nx, div_d_q;
	logic [32:0]        rsh;
	logic               div_ge;
	logic [31:0]        base_q, wl_q, fs_q;
	logic [63:0]        sq_v_q, sq_r_q, sq_b_q, sq_rb;
	logic [23:0]        amp_eff, wf_eff;
	logic [40:0]        ai_full;
	logic [48:0]        wl_full, rad_full, ar_full;
	logic [31:0]        wl_c;

	logic [31:0]        wn_q [NUM_WAVES];
	logic [31:0]        ar_q [NUM_WAVES];
	logic [24:0]        ai_q [NUM_WAVES];

	logic [PIPE_ST:1]   vld_q, adv;
	logic               full;
	wave_coef_t         coef_w [NUM_WAVES];
	logic signed [27:0] term_w [NGRP*4];
	logic signed [29:0] grp_s18 [NGRP];
	logic signed [29:0] grp_c [NGRP];
	logic signed [35:0] tot_s19, tot_c;
	logic [31:0]        height_s20;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_water_q <= 1'b1;
			level_q    <= 32'sd0;
			amp_q      <= 24'd65536;
			freq_q     <= 24'd65536;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE: en_water_q <= cfg_data[0];
				REG_LEVEL:  level_q    <= $signed(cfg_data);
				REG_AMP:    amp_q      <= cfg_data[23:0];
				REG_FREQ:   freq_q     <= cfg_data[23:0];
				default:    en_water_q <= en_water_q;
			endcase
		end
	end

	assign amp_eff = (amp_q < AMP_FLOOR) ? AMP_FLOOR : amp_q;
	assign wf_eff  = (freq_q < FREQ_FLOOR) ? FREQ_FLOOR : freq_q;
	assign widx    = 4'(wi_q);

	// one quotient bit per cycle
	always_comb begin
		rsh      = {div_r_q, div_n_q[40]};
		div_ge   = rsh >= {1'b0, div_d_q};
		div_r_nx = div_ge ? 32'(rsh - {1'b0, div_d_q}) : 32'(rsh);
		div_n_nx = {div_n_q[39:0], div_ge};
	end

	assign sq_rb    = sq_r_q + sq_b_q;
	assign ai_full  = 41'(amp_eff) * 41'(AMP_SCALE[widx]) + 41'd32768;
	assign wl_full  = 49'(base_q) * 49'(LEN_SCALE[widx]) + 49'd32768;
	assign wl_c     = 32'(wl_full >> 16);
	assign rad_full = 49'(G_OVER_2PI) * 49'(fs_q);
	assign ar_full  = 49'(sq_r_q[31:0]) * 49'(SPD_SCALE[widx]) + 49'd32768;

	// coefficient sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LDB;
			wi_q  <= '0;
			cnt_q <= '0;
		end else if (cfg_wen) begin
			st_q  <= ST_LDB;
			wi_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: st_q <= ST_IDLE;
				ST_LDB: begin
					st_q  <= ST_DIVB;
					cnt_q <= '0;
				end
				ST_DIVB: begin
					if (cnt_q == DIV_LAST) st_q <= ST_MULA;
					else cnt_q <= cnt_q + 1'b1;
				end
				ST_MULA: st_q <= ST_LDF;
				ST_LDF: begin
					st_q  <= ST_DIVF;
					cnt_q <= '0;
				end
				ST_DIVF: begin
					if (cnt_q == DIV_LAST) st_q <= ST_MULB;
					else cnt_q <= cnt_q + 1'b1;
				end
				ST_MULB: begin
					st_q  <= ST_SQRT;
					cnt_q <= '0;
				end
				ST_SQRT: begin
					if (cnt_q == SQ_LAST) st_q <= ST_MULC;
					else cnt_q <= cnt_q + 1'b1;
				end
				ST_MULC: begin
					if (wi_q == WI_W'(NUM_WAVES - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						wi_q <= wi_q + 1'b1;
						st_q <= ST_MULA;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_LDB: begin
				div_n_q <= BASE_NUM + 41'(wf_eff >> 1);
				div_d_q <= 32'(wf_eff);
				div_r_q <= '0;
			end
			ST_DIVB: begin
				div_n_q <= div_n_nx;
				div_r_q <= div_r_nx;
				if (cnt_q == DIV_LAST) base_q <= div_n_nx[31:0];
			end
			ST_MULA: begin
				wl_q       <= (wl_c < WL_FLOOR) ? WL_FLOOR : wl_c;
				ai_q[wi_q] <= ai_full[40:16];
			end
			ST_LDF: begin
				div_n_q <= FS_NUM + 41'(wl_q >> 1);
				div_d_q <= wl_q;
				div_r_q <= '0;
			end
			ST_DIVF: begin
				div_n_q <= div_n_nx;
				div_r_q <= div_r_nx;
				if (cnt_q == DIV_LAST) begin
					fs_q <= (|div_n_nx[40:32]) ? 32'hFFFF_FFFF : div_n_nx[31:0];
				end
			end
			ST_MULB: begin
				sq_v_q     <= {7'd0, rad_full, 8'd0};
				sq_r_q     <= '0;
				sq_b_q     <= 64'd1 << 62;
				wn_q[wi_q] <= fs_q;
			end
			ST_SQRT: begin
				if (sq_v_q >= sq_rb) begin
					sq_v_q <= sq_v_q - sq_rb;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			ST_MULC: begin
				ar_q[wi_q] <= (ar_full[48]) ? 32'hFFFF_FFFF : ar_full[47:16];
			end
			default: base_q <= base_q;
		endcase
	end

	// a stage moves when it or any later stage has a gap, or the output is taken
	always_comb begin
		full = 1'b1;
		for (int k = PIPE_ST; k >= 1; k--) begin
			full   = full & vld_q[k];
			adv[k] = m_tready | ~full;
		end
	end

	assign s_tready = adv[1] && (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= s_tvalid && s_tready;
			end
			for (int k = 2; k <= PIPE_ST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	for (genvar w = 0; w < NGRP * 4; w++) begin : g_lane
		if (w < NUM_WAVES) begin : g_on
			assign coef_w[w] = '{wn: wn_q[w], ar: ar_q[w], ai: ai_q[w]};
			owhs_lane #(
				.WAVE_IDX        (w),
				.SINE_TABLE_BITS (SINE_TABLE_BITS)
			) u_lane (
				.clk    (clk),
				.adv    (adv[LANE_ST:1]),
				.pos_x  ($signed(s_tdata[31:0])),
				.pos_z  ($signed(s_tdata[63:32])),
				.time_s (s_tdata[95:64]),
				.coef   (coef_w[w]),
				.term   (term_w[w])
			);
		end else begin : g_off
			assign term_w[w] = 28'sd0;
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = 30'(term_w[4*g]) + 30'(term_w[4*g+1])
				+ 30'(term_w[4*g+2]) + 30'(term_w[4*g+3]);
		end
		tot_c = 36'(level_q);
		for (int g = 0; g < NGRP; g++) begin
			tot_c = tot_c + 36'(grp_s18[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[18]) begin
			grp_s18 <= grp_c;
		end
		if (adv[19]) begin
			tot_s19 <= tot_c;
		end
		if (adv[20]) begin
			if (!en_water_q) begin
				height_s20 <= level_q;
			end else if (tot_s19 > 36'sd2147483647) begin
				height_s20 <= 32'h7FFF_FFFF;
			end else if (tot_s19 < -36'sd2147483648) begin
				height_s20 <= 32'h8000_0000;
			end else begin
				height_s20 <= tot_s19[31:0];
			end
		end
	end

	assign m_tvalid = vld_q[PIPE_ST];
	assign m_tdata  = height_s20;

`ifndef SYNTHESIS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !m_tready |-> !s_tready)
		else $error("request taken into a full stalled pipeline");
	a_gap_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[PIPE_ST] |-> (s_tready == (st_q == ST_IDLE)))
		else $error("input blocked although the pipeline has a gap");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> (st_q == ST_LDB))
		else $error("register write did not restart coefficient recompute");
`endif

endmodule

[bench/ocean_wave_height_synth_top_tb.sv]
// Self-checking testbench of the ocean wave height synthesiser, with its own height predictor.
`timescale 1ns / 1ps
module ocean_wave_height_synth_top_tb;
	import owhs_pkg::*;

	localparam int N_WAVES    = NUM_WAVES_DEF;
	localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
	localparam int LIMIT      = 600000;
	localparam longint unsigned M32 = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] time_s;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_x;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = REG_ENABLE;
	logic [31:0] cfg_data = '0;

	ocean_wave_height_synth_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor copy of the registers and derived wave coefficients
	logic        water_on;
	logic [31:0] level_q;
	logic [23:0] amp_q;
	logic [23:0] freq_q;
	longint unsigned k_turns [N_WAVES];
	longint unsigned w_turns [N_WAVES];

	sample_t     pending [$];
	logic [31:0] heights_due [$];
	int          errors = 0;
	int          n_checked = 0;
	int          n_cfg = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          rx_stall_req = 1'b0;
	int          tx_gap = 0;
	int          rx_hold = 0;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sat_u32(longint unsigned v);
		return (v > M32) ? M32 : v;
	endfunction

	function automatic void rederive_waves();
		longint unsigned wf, base, wl, fs, rt;
		int c;
		wf = (freq_q < FREQ_FLOOR) ? FREQ_FLOOR : freq_q;
		base = ((64'd30 << 32) + wf / 2) / wf;
		for (int i = 0; i < N_WAVES; i++) begin
			c = i % 6;
			wl = (base * LEN_SCALE[c] + 32768) >> 16;
			if (wl < 7)
				wl = 7;
			fs = sat_u32(((64'd1 << 40) + wl / 2) / wl);
			rt = root_floor((64'd102322 * fs) << 8);
			k_turns[i] = fs;
			w_turns[i] = sat_u32((rt * SPD_SCALE[c] + 32768) >> 16);
		end
	endfunction

	// CORDIC sine of an angle in turns (Q0.32), result Q16
	function automatic longint sine_of_turns(logic [31:0] a);
		longint r, mag, z, x, y, xs, ys, s;
		if (a[31:30] == 2'd1 || a[31:30] == 2'd2)
			a = 32'h8000_0000 - a;
		r = longint'(signed'(a));
		mag = (r < 0) ? -r : r;
		z = longint'((unsigned'(mag) * 411775 + 64'h8000_0000) >> 32);
		if (r < 0)
			z = -z;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_Q16[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_Q16[i]);
			end
		end
		s = (y + 8192) >>> 14;
		if (s > 65536) s = 65536;
		if (s < -65536) s = -65536;
		return s;
	endfunction

	function automatic logic [31:0] surface_height(sample_t smp);
		longint sum, d, ai;
		longint unsigned ps, pt, ph, amp;
		logic [31:0] ang;
		int c, sh;
		sum = longint'(signed'(level_q));
		if (!water_on)
			return level_q;
		amp = (amp_q < AMP_FLOOR) ? AMP_FLOOR : amp_q;
		sh = 32 - TABLE_BITS;
		for (int i = 0; i < N_WAVES; i++) begin
			c = i % 6;
			d = longint'(DIR_X[c]) * longint'(smp.pos_x) + longint'(DIR_Z[c]) * longint'(smp.pos_z);
			ps = ((k_turns[i] * unsigned'(d)) >> 24) & M32;
			pt = ((w_turns[i] * 64'(smp.time_s)) >> 8) & M32;
			ph = (ps + pt + (64'd1 << (sh - 1))) & M32;
			ang = 32'((ph >> sh) << sh);
			ai = longint'((amp * AMP_SCALE[c] + 32768) >> 16);
			sum += (ai * sine_of_turns(ang) + 32768) >>> 16;
		end
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	// sender: drives the oldest pending request, idles in random bursts
	always @(posedge clk or negedge arst_n) begin
		sample_t nxt;
		logic nv;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nv = s_tvalid;
			if (s_tvalid && s_tready) begin
				heights_due.push_back(surface_height(pending.pop_front()));
				nv = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					tx_gap = $urandom_range(1, 12);
				end else if (pending.size() > 0) begin
					nxt = pending[0];
					s_tdata <= nxt;
					nv = 1'b1;
				end
			end
			s_tvalid <= nv;
		end
	end

	// receiver: checks every height against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] due;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (heights_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected height %h", m_tdata);
				end else begin
					due = heights_due.pop_front();
					if (due !== m_tdata) begin
						errors++;
						if (errors <= 10)
							$display("height mismatch: expected %h actual %h", due, m_tdata);
					end
				end
			end
			if (rx_stall_req) begin
				rx_stall_req = 1'b0;
				rx_hold = 300;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				rx_hold = $urandom_range(1, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
			2: return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
			default: return {{8{1'b0}}, 24'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
		endcase
	endfunction

	task automatic add_random(int n);
		sample_t smp;
		for (int i = 0; i < n; i++) begin
			smp.pos_x = rand_coord();
			smp.pos_z = rand_coord();
			smp.time_s = ($urandom_range(0, 1) == 1) ? $urandom() : 32'($urandom_range(0, 1 << 24));
			pending.push_back(smp);
		end
	endtask

	task automatic drain();
		while (pending.size() > 0 || heights_due.size() > 0 || s_tvalid)
			@(posedge clk);
	endtask

	// write while idle; the block then recomputes its coefficients
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		drain();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE: water_on = val[0];
			REG_LEVEL:  level_q = val;
			REG_AMP:    amp_q = val[23:0];
			REG_FREQ:   freq_q = val[23:0];
			default:    water_on = water_on;
		endcase
		rederive_waves();
		n_cfg++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		sample_t smp;
		logic [31:0] corner [6];
		corner = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001};
		water_on = 1'b1;
		level_q = '0;
		amp_q = 24'd65536;
		freq_q = 24'd65536;
		rederive_waves();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of position and time at the reset settings
		for (int i = 0; i < 6; i++) begin
			smp.pos_x = corner[i];
			smp.pos_z = corner[(i + 2) % 6];
			smp.time_s = corner[(i + 4) % 6];
			pending.push_back(smp);
		end
		for (int i = 0; i < 6; i++) begin
			smp.pos_x = corner[5 - i];
			smp.pos_z = corner[i];
			smp.time_s = corner[i];
			pending.push_back(smp);
		end
		add_random(150);

		// water off, level at both extremes
		write_reg(REG_ENABLE, 32'd0);
		write_reg(REG_LEVEL, 32'h7FFF_FFFF);
		add_random(20);
		write_reg(REG_LEVEL, 32'h8000_0000);
		add_random(20);

		// floored amplitude and frequency
		write_reg(REG_ENABLE, 32'hFFFF_FFFE);
		write_reg(REG_ENABLE, 32'd1);
		write_reg(REG_AMP, 32'd0);
		write_reg(REG_FREQ, 32'd0);
		add_random(100);

		// largest amplitude and frequency, saturating sums at both level extremes
		write_reg(REG_AMP, 32'hFFFF_FFFF);
		write_reg(REG_FREQ, 32'h00FF_FFFF);
		add_random(60);
		write_reg(REG_LEVEL, 32'h7FFF_0000);
		add_random(60);

		// hold the receiver off while the sender keeps offering
		write_reg(REG_LEVEL, 32'hFFFC_0000);
		write_reg(REG_AMP, 32'($urandom_range(0, 1 << 24)));
		write_reg(REG_FREQ, 32'($urandom_range(600, 1 << 20)));
		rx_stall_req = 1'b1;
		add_random(80);
		drain();
		add_random(80);

		write_reg(REG_LEVEL, $urandom());
		write_reg(REG_AMP, 32'd65536);
		write_reg(REG_FREQ, 32'd6554);
		add_random(120);

		// last stretch without idling
		write_reg(REG_FREQ, 32'd65536);
		calm = 1'b1;
		add_random(180);
		drain();
		repeat (40) @(posedge clk);
		if (heights_due.size() != 0)
			errors++;
		$display("checked %0d heights over %0d register writes, %0d cycles",
			n_checked, n_cfg, cycles);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/owhs_pkg.sv
rtl/owhs_lane.sv
rtl/ocean_wave_height_synth_top.sv
bench/ocean_wave_height_synth_top_tb.sv
